// File: design/itda_pkg.sv
// ---------------------------------------------------------------------------
// itda_pkg
// Shared types and constants for the integer to decimal ASCII unit.
// ---------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

   // Character codes
   localparam logic [7:0] DIGIT_BASE_CODE = 8'd48;
   localparam logic [7:0] MINUS_CODE      = 8'd45;

   // Number of decimal places of a 32-bit magnitude, and the widths that follow
   localparam int unsigned NUM_PLACES = 10;
   localparam int unsigned POS_W      = $clog2(NUM_PLACES);
   localparam int unsigned MAG_W      = 32;
   // Wide enough to hold nine times the top power of ten plus a sign bit
   localparam int unsigned WIDE_W     = 35;
   localparam int unsigned DIGIT_W    = 4;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture a new input word
      logic sign_out;  // write the minus sign to the output register
      logic step;      // resolve one decimal place
   } itda_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic in_negative;  // sign of the word on the input channel
      logic final_place;  // working on the units place
      logic emit_digit;   // the current place produces a character
   } itda_stat_type;

   // Power of ten for a decimal place, zero-extended to the wide width
   function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] pos);
      logic [WIDE_W-1:0] p;
      case (pos)
         4'd0:    p = 35'd1;
         4'd1:    p = 35'd10;
         4'd2:    p = 35'd100;
         4'd3:    p = 35'd1000;
         4'd4:    p = 35'd10000;
         4'd5:    p = 35'd100000;
         4'd6:    p = 35'd1000000;
         4'd7:    p = 35'd10000000;
         4'd8:    p = 35'd100000000;
         4'd9:    p = 35'd1000000000;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// File: design/itda_datapath.sv
// ---------------------------------------------------------------------------
// itda_datapath
// Magnitude register, per-place digit resolver and output word register.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_datapath (
   input  wire logic                   clock,
   input  wire logic [31:0]            value,
   input  wire itda_pkg::itda_cmd_type cmd,
   output itda_pkg::itda_stat_type     stat,
   output logic [7:0]                  out_char,
   output logic                        out_last
);
   import itda_pkg::*;

   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               started_ff, started_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;

   logic [WIDE_W-1:0]  place_pow;
   logic [WIDE_W-1:0]  diff [1:9];
   logic [DIGIT_W-1:0] digit;
   logic [MAG_W-1:0]   rem;
   logic               emit;

   // Try all nine multiples of the place value at once, keep the largest that fits
   always_comb begin
      place_pow = pow10(pos_ff);
      digit     = '0;
      rem       = mag_ff;
      for (int k = 1; k <= 9; k++) begin
         diff[k] = {{(WIDE_W-MAG_W){1'b0}}, mag_ff} - place_pow * WIDE_W'(k);
         if (!diff[k][WIDE_W-1]) begin
            digit = DIGIT_W'(k);
            rem   = diff[k][MAG_W-1:0];
         end
      end
      emit = started_ff || (digit != '0) || (pos_ff == '0);
   end

   // Next-state of the working registers
   always_comb begin
      mag_in     = mag_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         mag_in     = value[31] ? (32'd0 - value) : value;
         pos_in     = POS_W'(NUM_PLACES - 1);
         started_in = 1'b0;
      end
      if (cmd.sign_out) begin
         char_in = MINUS_CODE;
         last_in = 1'b0;
      end
      if (cmd.step) begin
         mag_in     = rem;
         pos_in     = pos_ff - 1'b1;
         started_in = emit;
         if (emit) begin
            char_in = DIGIT_BASE_CODE + {4'd0, digit};
            last_in = (pos_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      pos_ff     <= pos_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign stat.in_negative = value[31];
   assign stat.final_place = (pos_ff == '0);
   assign stat.emit_digit  = emit;
   assign out_char         = char_ff;
   assign out_last         = last_ff;

endmodule

`default_nettype wire

// File: design/itda_ctrl.sv
// ---------------------------------------------------------------------------
// itda_ctrl
// Sequencer for one conversion and valid control of the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire itda_pkg::itda_stat_type stat,
   output itda_pkg::itda_cmd_type       cmd
);
   import itda_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SIGN  = 2'd1;
   localparam logic [1:0] ST_DIGIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;
   logic       out_load;

   // Output register can take a word when empty or being drained
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = stat.in_negative ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               cmd.sign_out = 1'b1;
               out_load     = 1'b1;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               cmd.step = 1'b1;
               out_load = stat.emit_digit;
               if (stat.final_place) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: cleared on drain, set on load
   always_comb begin
      valid_in = (out_free ? 1'b0 : valid_ff) | out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

// File: design/integer_to_decimal_ascii_unit.sv
// ---------------------------------------------------------------------------
// integer_to_decimal_ascii_unit
// Converts a signed 32-bit word into its decimal ASCII text, one character
// per output word, most significant digit first, last character flagged.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                       | tlast
//  req_    | in  | [31:0] value (signed)       | -
//  rsp_    | out | [7:0]  character            | last character of the number
//
// An input word is captured, then the minus sign is written when negative, then
// each decimal place is resolved in turn, all ten places by the parallel
// multiple compare whether or not they print (leading zeros skipped).
// Reset (synchronous) empties the output register and returns to idle.
// A stalled output holds the sequencer; the next word is accepted as soon as
// the units place is done, while its character may still wait in rsp_.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_decimal_ascii_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] character
   output logic             rsp_tlast
);
   import itda_pkg::*;

   itda_cmd_type  cmd;
   itda_stat_type stat;

   itda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   itda_datapath u_datapath (
      .clock    (clock),
      .value    (req_tdata),
      .cmd      (cmd),
      .stat     (stat),
      .out_char (rsp_tdata),
      .out_last (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: design/itda_checker.sv
// ---------------------------------------------------------------------------
// itda_checker
// Port-level checks for the integer to decimal ASCII unit.
// ---------------------------------------------------------------------------
`default_nettype none

module itda_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);
   import itda_pkg::*;

   // A stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // Only minus or digit characters come out
   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == MINUS_CODE) ||
                     (rsp_tdata >= DIGIT_BASE_CODE && rsp_tdata <= DIGIT_BASE_CODE + 8'd9))
      else $error("rsp character out of set");

   // The minus sign never ends a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == MINUS_CODE |-> !rsp_tlast)
      else $error("minus sign flagged last");

   // A conversion occupies the unit: no accept in the cycle after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted twice in a row");

   // A negative input accepted while the output register is empty is followed by the sign
   a_neg_sign: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[31] && !rsp_tvalid
      |=> ##1 rsp_tvalid && rsp_tdata == MINUS_CODE)
      else $error("negative input without leading minus");

endmodule

bind integer_to_decimal_ascii_unit itda_checker u_itda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
